### rtl/ray_offset_rigid_transform_unit_assert.svh
// Assertion macros for the ray offset transform unit checker.
// Needs i_clk and i_rst_n in the scope where a macro is used.
`ifndef RAY_OFFSET_RIGID_TRANSFORM_UNIT_ASSERT_SVH
`define RAY_OFFSET_RIGID_TRANSFORM_UNIT_ASSERT_SVH

// same-cycle implication
`define RORT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RORT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/rort_pkg.sv
// Shared widths, calibration constants and inter-stage word types.
// No dependencies.
`default_nettype none

package rort_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int PT_W       = 32;
    localparam int RAD_W      = 16;
    localparam int SQ_W       = 64;
    localparam int ROOT_W     = 32;
    localparam int REM_W      = 33;
    localparam int PR_W       = 49;
    localparam int NUM_W      = 48;
    localparam int OFFQ_W     = 17;
    localparam int OFF_W      = 18;
    localparam int Q_W        = 35;
    localparam int ROT_W      = 15;
    localparam int TR_W       = 16;
    localparam int PROD_W     = 50;
    localparam int ACC_W      = 52;
    localparam int MAG_W      = 47;
    localparam int QUOT_W     = 33;
    localparam int SCALE      = 10000;
    localparam int HALF_SCALE = SCALE / 2;

    // divide by 10000 as a shift by 4, then multiply by the reciprocal of 625;
    // exact for any 42-bit dividend
    localparam int DIV_PRE    = 4;
    localparam int DIVY_W     = 42;
    localparam int RECIP_W    = 43;
    localparam int RECIP_SH   = 52;
    localparam int Y_LO       = 21;
    localparam int R_LO       = 22;
    localparam int PP_W       = 43;
    localparam int PSUM_W     = RECIP_SH + QUOT_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SH) + 64'(SCALE >> DIV_PRE) - 64'd1)
                 / 64'(SCALE >> DIV_PRE));

    localparam logic [RAD_W-1:0] RADIUS_RESET = 16'd2294;

    // rotation and translation, both scaled by 10000
    localparam logic signed [ROT_W-1:0] ROT [0:2][0:2] = '{
        '{-15'sd7675, -15'sd1089,  15'sd6633},
        '{ 15'sd6524, -15'sd1114,  15'sd7391},
        '{ 15'sd271,   15'sd9741,  15'sd1440}
    };
    localparam logic signed [TR_W-1:0] TRANS [0:2] = '{
        16'sd14638, -16'sd13210, 16'sd13860
    };

    typedef struct packed {
        logic [SQ_W-1:0]            s;
        logic [2:0][PT_W-1:0]       p;
        logic [2:0][PR_W-1:0]       pr;
        logic                       inv;
    } t_front;

    typedef struct packed {
        logic [ROOT_W-1:0]          d;
        logic [2:0][PT_W-1:0]       p;
        logic [2:0][PR_W-1:0]       pr;
        logic                       inv;
    } t_root;

    typedef struct packed {
        logic [2:0][PT_W-1:0]       p;
        logic [2:0][OFF_W-1:0]      off;
        logic                       inv;
    } t_ray;

    typedef struct packed {
        logic [2:0][PT_W-1:0]       r;
        logic                       inv;
    } t_res;

endpackage

`default_nettype wire

### rtl/rort_front.sv
// Input register, squares and radius products, sum of squares.
// Depends on rort_pkg.
`default_nettype none

module rort_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire logic                         i_valid,
    input  wire logic [rort_pkg::PT_W-1:0]    i_point_x,
    input  wire logic [rort_pkg::PT_W-1:0]    i_point_y,
    input  wire logic [rort_pkg::PT_W-1:0]    i_point_z,
    input  wire logic [rort_pkg::RAD_W-1:0]   i_radius,
    output logic                              o_valid,
    output rort_pkg::t_front                  o_data
);

    logic                               r_a_v;
    logic [2:0][rort_pkg::PT_W-1:0]     r_a_p;
    logic                               r_b_v;
    logic [rort_pkg::SQ_W-1:0]          r_b_sq [0:2];
    logic [2:0][rort_pkg::PT_W-1:0]     r_b_p;
    logic [2:0][rort_pkg::PR_W-1:0]     r_b_pr;
    logic                               r_b_inv;
    logic                               r_c_v;
    rort_pkg::t_front                   r_c;

    logic signed [rort_pkg::SQ_W-1:0]   w_sq [0:2];
    logic signed [rort_pkg::PR_W-1:0]   w_pr [0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
        end else if (i_en) begin
            r_a_v <= i_valid;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
        end
    end

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            w_sq[l] = $signed(r_a_p[l]) * $signed(r_a_p[l]);
            w_pr[l] = $signed(r_a_p[l]) * $signed({1'b0, i_radius});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_p   <= {i_point_z, i_point_y, i_point_x};
            for (int l = 0; l < 3; l++) begin
                r_b_sq[l] <= w_sq[l];
                r_b_pr[l] <= w_pr[l];
            end
            r_b_p   <= r_a_p;
            r_b_inv <= (r_a_p == '0);
            r_c.s   <= r_b_sq[0] + r_b_sq[1] + r_b_sq[2];
            r_c.p   <= r_b_p;
            r_c.pr  <= r_b_pr;
            r_c.inv <= r_b_inv;
        end
    end

    assign o_valid = r_c_v;
    assign o_data  = r_c;

endmodule

`default_nettype wire

### rtl/rort_isqrt.sv
// Pipelined integer square root, two radicand bits per stage.
// Depends on rort_pkg.
`default_nettype none

module rort_isqrt (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic               i_valid,
    input  wire rort_pkg::t_front   i_data,
    output logic                    o_valid,
    output rort_pkg::t_root         o_data
);

    localparam int STAGES = rort_pkg::ROOT_W;

    logic                               a_v    [0:STAGES];
    logic [rort_pkg::REM_W-1:0]         a_rem  [0:STAGES];
    logic [rort_pkg::ROOT_W-1:0]        a_root [0:STAGES];
    rort_pkg::t_front                   a_pl   [0:STAGES];

    assign a_v[0]    = i_valid;
    assign a_rem[0]  = '0;
    assign a_root[0] = '0;
    assign a_pl[0]   = i_data;

    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        logic                               r_v;
        logic [rort_pkg::REM_W-1:0]         r_rem;
        logic [rort_pkg::ROOT_W-1:0]        r_root;
        rort_pkg::t_front                   r_pl;
        logic [rort_pkg::ROOT_W+2:0]        w_rin;
        logic [rort_pkg::ROOT_W+2:0]        w_trial;
        logic [rort_pkg::ROOT_W+2:0]        w_diff;
        logic                               w_ge;

        assign w_rin   = {a_rem[g], a_pl[g].s[rort_pkg::SQ_W-1 -: 2]};
        assign w_trial = {1'b0, a_root[g], 2'b01};
        assign w_ge    = (w_rin >= w_trial);
        assign w_diff  = w_rin - w_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= a_v[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem    <= w_ge ? w_diff[rort_pkg::REM_W-1:0] : w_rin[rort_pkg::REM_W-1:0];
                r_root   <= {a_root[g][rort_pkg::ROOT_W-2:0], w_ge};
                r_pl.s   <= {a_pl[g].s[rort_pkg::SQ_W-3:0], 2'b00};
                r_pl.p   <= a_pl[g].p;
                r_pl.pr  <= a_pl[g].pr;
                r_pl.inv <= a_pl[g].inv;
            end
        end

        assign a_v[g+1]    = r_v;
        assign a_rem[g+1]  = r_rem;
        assign a_root[g+1] = r_root;
        assign a_pl[g+1]   = r_pl;
    end

    assign o_valid = a_v[STAGES];
    assign o_data  = {a_root[STAGES], a_pl[STAGES].p, a_pl[STAGES].pr, a_pl[STAGES].inv};

endmodule

`default_nettype wire

### rtl/rort_div.sv
// Ray offset: rounded p*r/d per axis, restoring divider, one quotient bit a stage.
// Depends on rort_pkg.
`default_nettype none

module rort_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic               i_valid,
    input  wire rort_pkg::t_root    i_data,
    output logic                    o_valid,
    output rort_pkg::t_ray          o_data
);

    localparam int STAGES = rort_pkg::OFFQ_W;

    logic                               r_v   [0:STAGES];
    logic [rort_pkg::ROOT_W-1:0]        r_d   [0:STAGES];
    logic [2:0][rort_pkg::PT_W-1:0]     r_p   [0:STAGES];
    logic                               r_inv [0:STAGES];
    logic [rort_pkg::NUM_W-1:0]         r_rem [0:STAGES][0:2];
    logic [rort_pkg::OFFQ_W-1:0]        r_q   [0:STAGES][0:2];
    logic                               r_neg [0:STAGES][0:2];

    logic [rort_pkg::PR_W-1:0]          w_mag [0:2];

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            w_mag[l] = i_data.pr[l][rort_pkg::PR_W-1] ? -i_data.pr[l] : i_data.pr[l];
        end
    end

    // setup: magnitude plus half the divisor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d[0]   <= i_data.d;
            r_p[0]   <= i_data.p;
            r_inv[0] <= i_data.inv;
            for (int l = 0; l < 3; l++) begin
                r_rem[0][l] <= w_mag[l][rort_pkg::NUM_W-1:0]
                             + rort_pkg::NUM_W'(i_data.d[rort_pkg::ROOT_W-1:1]);
                r_q[0][l]   <= '0;
                r_neg[0][l] <= i_data.pr[l][rort_pkg::PR_W-1];
            end
        end
    end

    for (genvar g = 1; g <= STAGES; g++) begin : g_stage
        logic [rort_pkg::NUM_W:0] w_t;

        assign w_t = rort_pkg::NUM_W'(r_d[g-1]) << (STAGES - g);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_en) begin
                r_v[g] <= r_v[g-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_d[g]   <= r_d[g-1];
                r_p[g]   <= r_p[g-1];
                r_inv[g] <= r_inv[g-1];
                for (int l = 0; l < 3; l++) begin
                    r_neg[g][l] <= r_neg[g-1][l];
                    if ({1'b0, r_rem[g-1][l]} >= w_t) begin
                        r_rem[g][l] <= r_rem[g-1][l] - w_t[rort_pkg::NUM_W-1:0];
                        r_q[g][l]   <= {r_q[g-1][l][rort_pkg::OFFQ_W-2:0], 1'b1};
                    end else begin
                        r_rem[g][l] <= r_rem[g-1][l];
                        r_q[g][l]   <= {r_q[g-1][l][rort_pkg::OFFQ_W-2:0], 1'b0};
                    end
                end
            end
        end
    end

    always_comb begin
        o_data.p   = r_p[STAGES];
        o_data.inv = r_inv[STAGES];
        for (int l = 0; l < 3; l++) begin
            o_data.off[l] = r_neg[STAGES][l] ? -{1'b0, r_q[STAGES][l]}
                                             :  {1'b0, r_q[STAGES][l]};
        end
    end

    assign o_valid = r_v[STAGES];

endmodule

`default_nettype wire

### rtl/rort_xform.sv
// Calibration transform: ball centre, 3x3 products, sums, rounded /10000 by
// reciprocal multiplication, saturation. Depends on rort_pkg.
`default_nettype none

module rort_xform (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic               i_valid,
    input  wire rort_pkg::t_ray     i_data,
    output logic                    o_valid,
    output rort_pkg::t_res          o_data
);

    localparam logic [rort_pkg::QUOT_W-1:0] NEG_LIM = rort_pkg::QUOT_W'(1) << (rort_pkg::PT_W-1);
    localparam logic [rort_pkg::QUOT_W-1:0] POS_LIM = NEG_LIM - 1'b1;

    logic                               r1_v, r2_v, r3_v, r4_v, r5_v, r6_v, r7_v;
    logic                               r1_inv, r2_inv, r3_inv, r4_inv, r5_inv, r6_inv, r7_inv;
    logic signed [rort_pkg::Q_W-1:0]    r1_q [0:2];
    logic signed [rort_pkg::PROD_W-1:0] r2_prod [0:2][0:2];
    logic signed [rort_pkg::ACC_W-1:0]  r3_acc [0:2];
    logic [rort_pkg::DIVY_W-1:0]        r4_y [0:2];
    logic [2:0]                         r4_neg, r5_neg, r6_neg, r7_neg;
    logic [rort_pkg::PP_W-1:0]          r5_hh [0:2];
    logic [rort_pkg::PP_W-1:0]          r5_hl [0:2];
    logic [rort_pkg::PP_W-1:0]          r5_lh [0:2];
    logic [rort_pkg::PP_W-1:0]          r5_ll [0:2];
    logic [rort_pkg::PSUM_W-1:0]        r6_a [0:2];
    logic [rort_pkg::PSUM_W-1:0]        r6_b [0:2];
    logic [rort_pkg::QUOT_W-1:0]        r7_q [0:2];

    logic                               r_f_v;
    rort_pkg::t_res                     r_f;

    logic [rort_pkg::ACC_W-1:0]         w_mag [0:2];
    logic [rort_pkg::MAG_W-1:0]         w_rnd [0:2];
    logic [rort_pkg::PSUM_W-1:0]        w_sum [0:2];
    logic [rort_pkg::PT_W-1:0]          w_sat [0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v  <= 1'b0;
            r2_v  <= 1'b0;
            r3_v  <= 1'b0;
            r4_v  <= 1'b0;
            r5_v  <= 1'b0;
            r6_v  <= 1'b0;
            r7_v  <= 1'b0;
            r_f_v <= 1'b0;
        end else if (i_en) begin
            r1_v  <= i_valid;
            r2_v  <= r1_v;
            r3_v  <= r2_v;
            r4_v  <= r3_v;
            r5_v  <= r4_v;
            r6_v  <= r5_v;
            r7_v  <= r6_v;
            r_f_v <= r7_v;
        end
    end

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            w_mag[l] = r3_acc[l][rort_pkg::ACC_W-1] ? -r3_acc[l] : r3_acc[l];
            // magnitude with half the scale added, for rounding away from zero
            w_rnd[l] = w_mag[l][rort_pkg::MAG_W-1:0] + rort_pkg::MAG_W'(rort_pkg::HALF_SCALE);
            w_sum[l] = r6_a[l] + r6_b[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < 3; l++) begin
                r1_q[l] <= rort_pkg::Q_W'($signed(i_data.p[l]))
                         + rort_pkg::Q_W'($signed(i_data.off[l]));
                for (int j = 0; j < 3; j++) begin
                    r2_prod[l][j] <= rort_pkg::ROT[l][j] * r1_q[j];
                end
                r3_acc[l] <= rort_pkg::ACC_W'(r2_prod[l][0])
                           + rort_pkg::ACC_W'(r2_prod[l][1])
                           + rort_pkg::ACC_W'(r2_prod[l][2])
                           + (rort_pkg::ACC_W'(rort_pkg::TRANS[l]) <<< rort_pkg::FRAC_BITS);
                r4_y[l]   <= w_rnd[l][rort_pkg::DIVY_W+rort_pkg::DIV_PRE-1:rort_pkg::DIV_PRE];
                r4_neg[l] <= r3_acc[l][rort_pkg::ACC_W-1];
                // split the 42 x 43 bit reciprocal product into four partial products
                r5_hh[l]  <= r4_y[l][rort_pkg::DIVY_W-1:rort_pkg::Y_LO]
                           * rort_pkg::RECIP[rort_pkg::RECIP_W-1:rort_pkg::R_LO];
                r5_hl[l]  <= r4_y[l][rort_pkg::DIVY_W-1:rort_pkg::Y_LO]
                           * rort_pkg::RECIP[rort_pkg::R_LO-1:0];
                r5_lh[l]  <= r4_y[l][rort_pkg::Y_LO-1:0]
                           * rort_pkg::RECIP[rort_pkg::RECIP_W-1:rort_pkg::R_LO];
                r5_ll[l]  <= r4_y[l][rort_pkg::Y_LO-1:0]
                           * rort_pkg::RECIP[rort_pkg::R_LO-1:0];
                r6_a[l]   <= (rort_pkg::PSUM_W'(r5_hh[l]) << (rort_pkg::Y_LO + rort_pkg::R_LO))
                           + (rort_pkg::PSUM_W'(r5_lh[l]) << rort_pkg::R_LO);
                r6_b[l]   <= (rort_pkg::PSUM_W'(r5_hl[l]) << rort_pkg::Y_LO)
                           + rort_pkg::PSUM_W'(r5_ll[l]);
                r7_q[l]   <= w_sum[l][rort_pkg::PSUM_W-1 -: rort_pkg::QUOT_W];
                r_f.r[l]  <= w_sat[l];
            end
            r5_neg  <= r4_neg;
            r6_neg  <= r5_neg;
            r7_neg  <= r6_neg;
            r1_inv  <= i_data.inv;
            r2_inv  <= r1_inv;
            r3_inv  <= r2_inv;
            r4_inv  <= r3_inv;
            r5_inv  <= r4_inv;
            r6_inv  <= r5_inv;
            r7_inv  <= r6_inv;
            r_f.inv <= r7_inv;
        end
    end

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            if (r7_inv) begin
                w_sat[l] = '0;
            end else if (r7_neg[l]) begin
                w_sat[l] = (r7_q[l] > NEG_LIM) ? NEG_LIM[rort_pkg::PT_W-1:0]
                                               : -r7_q[l][rort_pkg::PT_W-1:0];
            end else begin
                w_sat[l] = (r7_q[l] > POS_LIM) ? POS_LIM[rort_pkg::PT_W-1:0]
                                               : r7_q[l][rort_pkg::PT_W-1:0];
            end
        end
    end

    assign o_valid = r_f_v;
    assign o_data  = r_f;

endmodule

`default_nettype wire

### rtl/ray_offset_rigid_transform_unit.sv
// Ray offset and rigid calibration transform, top level with output skid buffer.
// Depends on rort_pkg, rort_front, rort_isqrt, rort_div, rort_xform.
`default_nettype none

// Takes one camera-frame point (signed Q16.16) per cycle while o_stall is low, pushes
// it out along its ray from the origin by the radius register and maps the ball centre
// into the robot frame with the fixed calibration, saturating to 32 bits. A point at
// the origin gives zeros with o_invalid set. Fully pipelined: one word per clock
// sustained while o_stall is low. The word passes 62 register stages: the input
// front end, the 32-stage square root, the 18-stage offset divider, the 8-stage
// transform with its reciprocal divide by 10000 and the output register. A stalled
// output word is parked in a skid register; o_stall is registered and rises only
// while it is full. The radius is written through i_cfg_we / i_cfg_data; the user
// must write it only while no word is in flight; the block does not enforce this.

module ray_offset_rigid_transform_unit (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [rort_pkg::RAD_W-1:0]   i_cfg_data,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic [rort_pkg::PT_W-1:0]    i_point_x,
    input  wire logic [rort_pkg::PT_W-1:0]    i_point_y,
    input  wire logic [rort_pkg::PT_W-1:0]    i_point_z,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic [rort_pkg::PT_W-1:0]         o_robot_x,
    output logic [rort_pkg::PT_W-1:0]         o_robot_y,
    output logic [rort_pkg::PT_W-1:0]         o_robot_z,
    output logic                              o_invalid
);

    logic [rort_pkg::RAD_W-1:0]  r_radius;
    logic                        w_en;
    logic                        w_front_v, w_root_v, w_ray_v, w_res_v;
    rort_pkg::t_front            w_front;
    rort_pkg::t_root             w_root;
    rort_pkg::t_ray              w_ray;
    rort_pkg::t_res              w_res;

    logic                        r_ov, r_sv;
    rort_pkg::t_res              r_od, r_sd;
    logic                        w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= rort_pkg::RADIUS_RESET;
        end else if (i_cfg_we) begin
            r_radius <= i_cfg_data;
        end
    end

    // whole pipeline moves unless the skid register is occupied
    assign w_en = !r_sv;

    rort_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (i_valid),
        .i_point_x (i_point_x),
        .i_point_y (i_point_y),
        .i_point_z (i_point_z),
        .i_radius  (r_radius),
        .o_valid   (w_front_v),
        .o_data    (w_front)
    );

    rort_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_front_v),
        .i_data  (w_front),
        .o_valid (w_root_v),
        .o_data  (w_root)
    );

    rort_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_root_v),
        .i_data  (w_root),
        .o_valid (w_ray_v),
        .o_data  (w_ray)
    );

    rort_xform u_xform (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_ray_v),
        .i_data  (w_ray),
        .o_valid (w_res_v),
        .o_data  (w_res)
    );

    assign w_out_free = !r_ov || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (w_out_free) begin
            if (r_sv) begin
                r_ov <= 1'b1;
                r_sv <= 1'b0;
            end else begin
                r_ov <= w_res_v;
            end
        end else if (w_res_v && w_en) begin
            r_sv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            r_od <= r_sv ? r_sd : w_res;
        end else if (w_en) begin
            r_sd <= w_res;
        end
    end

    assign o_stall   = r_sv;
    assign o_valid   = r_ov;
    assign o_robot_x = r_od.r[0];
    assign o_robot_y = r_od.r[1];
    assign o_robot_z = r_od.r[2];
    assign o_invalid = r_od.inv;

endmodule

`default_nettype wire

### rtl/rort_checker.sv
// Port-level checks for the ray offset transform unit, bound to the top level.
// Depends on ray_offset_rigid_transform_unit_assert.svh.
`default_nettype none

`include "ray_offset_rigid_transform_unit_assert.svh"

module rort_checker (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          o_valid,
    input  wire logic          i_stall,
    input  wire logic          o_stall,
    input  wire logic [31:0]   o_robot_x,
    input  wire logic [31:0]   o_robot_y,
    input  wire logic [31:0]   o_robot_z,
    input  wire logic          o_invalid
);

    `RORT_ASSERT_NXT(a_out_hold, o_valid && i_stall, o_valid, "output word dropped while stalled")
    `RORT_ASSERT_NXT(a_out_stable, o_valid && i_stall, $stable(o_robot_x) && $stable(o_robot_y) && $stable(o_robot_z) && $stable(o_invalid), "output word changed while stalled")
    `RORT_ASSERT_IMP(a_inv_zero, o_valid && o_invalid, o_robot_x == 32'd0 && o_robot_y == 32'd0 && o_robot_z == 32'd0, "invalid word carries non-zero coordinates")
    `RORT_ASSERT_IMP(a_stall_cause, $rose(o_stall), $past(o_valid && i_stall), "input stall raised without a stalled output word")
    `RORT_ASSERT_NXT(a_stall_drain, o_stall && !i_stall, !o_stall, "skid word not drained when output freed")

endmodule

bind ray_offset_rigid_transform_unit rort_checker u_rort_checker (.*);

`default_nettype wire
